/* hdl/cfrc_pkg.sv */
package cfrc_pkg;

  localparam int FRAME_LENGTH = 10;
  localparam int STORE_DEPTH  = 16;
  localparam int POS_W        = $clog2(STORE_DEPTH);

  localparam logic [7:0] START_BYTE         = 8'h7E;
  localparam logic [7:0] END_BYTE           = 8'hEF;
  localparam logic [7:0] PLAYBACK_DONE_CODE = 8'h3E;
  localparam logic [15:0] CHECKSUM_MASK     = 16'hFFFF;

  // store slots that a finished frame is read from
  localparam int SUM_FIRST      = 1;
  localparam int SUM_LAST       = 6;
  localparam int CMD_SLOT       = 3;
  localparam int FEEDBACK_SLOT  = 4;
  localparam int PARAM_HI_SLOT  = 5;
  localparam int PARAM_LO_SLOT  = 6;
  localparam int CHECK_HI_SLOT  = 7;
  localparam int CHECK_LO_SLOT  = 8;

  localparam int SUM_W = 11;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [7:0]       byte_t;

  typedef struct packed {
    logic        checksum_ok;
    logic [7:0]  command_code;
    logic [7:0]  feedback_byte;
    logic [15:0] parameter_word;
    logic        playback_finished;
  } result_t;

endpackage

/* hdl/command_frame_receiver_checker.sv */
// channel  | handshake           | payload
// ---------+---------------------+--------------------------------------------
// input    | in_valid / in_stall | rx_byte
// output   | out_valid/out_stall | checksum_ok, command_code, feedback_byte,
//          |                     | parameter_word, playback_finished
//
// a byte sits in the input register after acceptance, then the
// position/store update and frame decode land in the result register.
// one byte per cycle sustained while out_stall holds no result; the single position register sets that loop.
// reset clears the position and both valid flags; the frame store is not reset.
// while a result waits under out_stall, one more byte is taken into the input
// register; further bytes stall until the result is taken.
module command_frame_receiver_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        checksum_ok,
  output logic [7:0]  command_code,
  output logic [7:0]  feedback_byte,
  output logic [15:0] parameter_word,
  output logic        playback_finished
);

  localparam int POS_W = cfrc_pkg::POS_W;

  logic                in_reg_valid;
  cfrc_pkg::byte_t     in_reg;
  cfrc_pkg::pos_t      pos;
  cfrc_pkg::pos_t      pos_next;
  cfrc_pkg::byte_t     frame_store [cfrc_pkg::STORE_DEPTH];
  cfrc_pkg::result_t   result;
  cfrc_pkg::result_t   result_next;

  logic                advance;
  logic                accept;
  logic                emit;
  cfrc_pkg::pos_t      wr_pos;
  logic [POS_W:0]      pos_inc;
  logic [cfrc_pkg::SUM_W-1:0] sum;
  logic [15:0]         computed;
  logic [15:0]         received;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = in_reg_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // position update for the byte held in the input register
  always_comb begin
    wr_pos  = (in_reg == cfrc_pkg::START_BYTE) ? '0 : pos;
    pos_inc = {1'b0, wr_pos} + {{POS_W{1'b0}}, 1'b1};
    if (pos_inc >= (POS_W+1)'(cfrc_pkg::STORE_DEPTH)) begin
      pos_inc = '0;
    end
    emit = (in_reg == cfrc_pkg::END_BYTE) &&
           (pos_inc == (POS_W+1)'(cfrc_pkg::FRAME_LENGTH));
    pos_next = emit ? '0 : pos_inc[POS_W-1:0];
  end

  // decode; the current byte goes to slot nine, so slots 1..8 are settled
  always_comb begin
    sum = '0;
    for (int i = cfrc_pkg::SUM_FIRST; i <= cfrc_pkg::SUM_LAST; i++) begin
      sum = sum + {{(cfrc_pkg::SUM_W-8){1'b0}}, frame_store[i]};
    end
    computed = 16'(17'h1_0000 - {6'b0, sum}) & cfrc_pkg::CHECKSUM_MASK;
    received = {frame_store[cfrc_pkg::CHECK_HI_SLOT], frame_store[cfrc_pkg::CHECK_LO_SLOT]};
    result_next.checksum_ok       = (received == computed);
    result_next.command_code      = frame_store[cfrc_pkg::CMD_SLOT];
    result_next.feedback_byte     = frame_store[cfrc_pkg::FEEDBACK_SLOT];
    result_next.parameter_word    = {frame_store[cfrc_pkg::PARAM_HI_SLOT],
                                     frame_store[cfrc_pkg::PARAM_LO_SLOT]};
    result_next.playback_finished =
      (frame_store[cfrc_pkg::CMD_SLOT] == cfrc_pkg::PLAYBACK_DONE_CODE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      pos          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        in_reg_valid <= 1'b1;
      end else if (advance) begin
        in_reg_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= in_reg_valid && emit;
        if (in_reg_valid) begin
          pos <= pos_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg <= rx_byte;
    end
    if (advance && in_reg_valid) begin
      frame_store[wr_pos] <= in_reg;
      if (emit) begin
        result <= result_next;
      end
    end
  end

  assign checksum_ok       = result.checksum_ok;
  assign command_code      = result.command_code;
  assign feedback_byte     = result.feedback_byte;
  assign parameter_word    = result.parameter_word;
  assign playback_finished = result.playback_finished;

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, pos} < (POS_W+1)'(cfrc_pkg::STORE_DEPTH))
    else $error("write position out of store range");

  a_pos_clear_after_frame: assert property (@(posedge clk) disable iff (rst)
    (advance && in_reg_valid && emit) |=> (pos == '0 && out_valid))
    else $error("frame end did not clear position or raise a result");

  a_playback_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (playback_finished == (command_code == cfrc_pkg::PLAYBACK_DONE_CODE)))
    else $error("playback flag does not match command code");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (rst)
    (in_reg_valid && out_valid && out_stall) |=> (in_reg_valid && $stable(in_reg)))
    else $error("buffered transaction lost while output stalled");

endmodule

/* dv/tb_command_frame_receiver_checker.sv */
`timescale 1ns / 100ps

module tb_command_frame_receiver_checker;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX   = 10;

  logic            clk;
  logic            rst;
  logic            in_valid = 1'b0;
  logic            in_stall;
  cfrc_pkg::byte_t rx_byte = 8'h00;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic            checksum_ok;
  cfrc_pkg::byte_t command_code;
  cfrc_pkg::byte_t feedback_byte;
  logic [15:0]     parameter_word;
  logic            playback_finished;

  command_frame_receiver_checker DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .rx_byte           (rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .checksum_ok       (checksum_ok),
    .command_code      (command_code),
    .feedback_byte     (feedback_byte),
    .parameter_word    (parameter_word),
    .playback_finished (playback_finished)
  );

  cfrc_pkg::byte_t   rx_bytes_q[$];
  cfrc_pkg::result_t frames_q[$];

  // frame decoder state mirrored from the block
  int              rx_pos = 0;
  cfrc_pkg::byte_t rx_store[cfrc_pkg::STORE_DEPTH];

  int bytes_total;
  int bytes_taken;
  int frames_seen;
  int frames_good;
  int frames_done;
  int mismatches;
  int cycles;
  int tx_idle_pct = 21;
  int rx_idle_pct = 65;
  bit in_taken;

  function automatic cfrc_pkg::byte_t rand_byte();
    return cfrc_pkg::byte_t'($urandom);
  endfunction

  function automatic cfrc_pkg::byte_t rand_data_byte();
    cfrc_pkg::byte_t b;
    b = rand_byte();
    if (b == cfrc_pkg::START_BYTE) b = b ^ 8'h01;
    return b;
  endfunction

  task automatic push_frame(input cfrc_pkg::byte_t first, input cfrc_pkg::byte_t ver,
                            input cfrc_pkg::byte_t len, input cfrc_pkg::byte_t cmd,
                            input cfrc_pkg::byte_t fb, input logic [15:0] param,
                            input bit corrupt);
    logic [15:0] sum;
    logic [15:0] ck;
    sum = 16'(ver) + 16'(len) + 16'(cmd) + 16'(fb) + 16'(param[15:8]) + 16'(param[7:0]);
    ck  = 16'h0000 - sum;
    if (corrupt) ck = ck ^ 16'($urandom_range(1, 65535));
    rx_bytes_q.push_back(first);
    rx_bytes_q.push_back(ver);
    rx_bytes_q.push_back(len);
    rx_bytes_q.push_back(cmd);
    rx_bytes_q.push_back(fb);
    rx_bytes_q.push_back(param[15:8]);
    rx_bytes_q.push_back(param[7:0]);
    rx_bytes_q.push_back(ck[15:8]);
    rx_bytes_q.push_back(ck[7:0]);
    rx_bytes_q.push_back(cfrc_pkg::END_BYTE);
  endtask

  task automatic push_random_frame(input cfrc_pkg::byte_t first);
    cfrc_pkg::byte_t ver;
    cfrc_pkg::byte_t len;
    cfrc_pkg::byte_t cmd;
    logic [15:0]     param;
    int              pick;
    ver = ($urandom_range(1) != 0) ? 8'hFF : rand_byte();
    len = ($urandom_range(1) != 0) ? 8'h06 : rand_byte();
    cmd = ($urandom_range(99) < 20) ? cfrc_pkg::PLAYBACK_DONE_CODE : rand_byte();
    pick = $urandom_range(9);
    if (pick == 0) param = 16'h0000;
    else if (pick == 1) param = 16'hFFFF;
    else param = 16'($urandom);
    push_frame(first, ver, len, cmd, rand_byte(), param, $urandom_range(99) < 25);
  endtask

  // one received byte through the decoder, queue a frame when one completes
  task automatic decode_rx_byte(input cfrc_pkg::byte_t b);
    cfrc_pkg::result_t r;
    logic [15:0]       sum;
    logic [15:0]       rcvd;
    if (b == cfrc_pkg::START_BYTE) rx_pos = 0;
    rx_store[rx_pos] = b;
    rx_pos++;
    if (rx_pos >= cfrc_pkg::STORE_DEPTH) rx_pos = 0;
    if (b == cfrc_pkg::END_BYTE && rx_pos == cfrc_pkg::FRAME_LENGTH) begin
      sum = 16'h0000;
      for (int i = 1; i <= 6; i++) sum = sum + 16'(rx_store[i]);
      rcvd = {rx_store[7], rx_store[8]};
      // received word is the two's complement of the sum when both add to zero
      r.checksum_ok       = ((rcvd + sum) == 16'h0000);
      r.command_code      = rx_store[3];
      r.feedback_byte     = rx_store[4];
      r.parameter_word    = {rx_store[5], rx_store[6]};
      r.playback_finished = (rx_store[3] == cfrc_pkg::PLAYBACK_DONE_CODE);
      frames_q.push_back(r);
      rx_pos = 0;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frames still pending", cycles, frames_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // driver: new transaction only once the previous one was taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (rx_bytes_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte  <= rx_bytes_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // monitor: outputs checked before the byte taken on the same edge is decoded
  always @(posedge clk) begin
    cfrc_pkg::result_t got;
    cfrc_pkg::result_t want;
    in_taken = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.checksum_ok       = checksum_ok;
        got.command_code      = command_code;
        got.feedback_byte     = feedback_byte;
        got.parameter_word    = parameter_word;
        got.playback_finished = playback_finished;
        frames_seen++;
        if (frames_q.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: unexpected frame ok=%0b cmd=%02h fb=%02h param=%04h done=%0b",
                     $realtime, got.checksum_ok, got.command_code, got.feedback_byte,
                     got.parameter_word, got.playback_finished);
          mismatches++;
        end else begin
          want = frames_q.pop_front();
          if (want.checksum_ok) frames_good++;
          if (want.playback_finished) frames_done++;
          if (got.checksum_ok !== want.checksum_ok ||
              got.command_code !== want.command_code ||
              got.feedback_byte !== want.feedback_byte ||
              got.parameter_word !== want.parameter_word ||
              got.playback_finished !== want.playback_finished) begin
            if (mismatches < REPORT_MAX) begin
              $display("%0t: frame mismatch", $realtime);
              $display("  expected ok=%0b cmd=%02h fb=%02h param=%04h done=%0b",
                       want.checksum_ok, want.command_code, want.feedback_byte,
                       want.parameter_word, want.playback_finished);
              $display("  actual   ok=%0b cmd=%02h fb=%02h param=%04h done=%0b",
                       got.checksum_ok, got.command_code, got.feedback_byte,
                       got.parameter_word, got.playback_finished);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        decode_rx_byte(rx_byte);
        bytes_taken++;
        if (bytes_taken < bytes_total / 3) begin
          tx_idle_pct = 21;
          rx_idle_pct = 65;
        end else if (bytes_taken < (2 * bytes_total) / 3) begin
          tx_idle_pct = 65;
          rx_idle_pct = 21;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      end
    end
  end

  initial begin
    int              kind;
    int              n;
    int              directed_len;
    cfrc_pkg::byte_t b;
    rst = 1'b1;

    // clean frame carrying the playback finished code
    push_frame(cfrc_pkg::START_BYTE, 8'hFF, 8'h06, cfrc_pkg::PLAYBACK_DONE_CODE, 8'h00,
               16'h0000, 1'b0);
    // end byte too early, then a start byte in the middle of a frame
    rx_bytes_q.push_back(cfrc_pkg::START_BYTE);
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(cfrc_pkg::END_BYTE);
    rx_bytes_q.push_back(cfrc_pkg::START_BYTE);
    rx_bytes_q.push_back(8'hFF);
    rx_bytes_q.push_back(8'h06);
    // restarted frame with command, feedback and parameter at max and a broken checksum
    push_frame(cfrc_pkg::START_BYTE, 8'h00, 8'h00, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);
    directed_len = rx_bytes_q.size();

    while (rx_bytes_q.size() < directed_len + RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        push_random_frame(cfrc_pkg::START_BYTE);
      end else if (kind < 68) begin
        // truncated frame
        rx_bytes_q.push_back(cfrc_pkg::START_BYTE);
        repeat ($urandom_range(1, 8)) rx_bytes_q.push_back(rand_byte());
      end else if (kind < 76) begin
        // noise heavy on start and end bytes
        repeat ($urandom_range(1, 12)) begin
          n = $urandom_range(9);
          b = (n == 0) ? cfrc_pkg::START_BYTE : (n < 3) ? cfrc_pkg::END_BYTE : rand_byte();
          rx_bytes_q.push_back(b);
        end
      end else if (kind < 86) begin
        // end byte off the frame length
        n = $urandom_range(1, 13);
        if (n == cfrc_pkg::FRAME_LENGTH - 2) n++;
        rx_bytes_q.push_back(cfrc_pkg::START_BYTE);
        repeat (n) rx_bytes_q.push_back(rand_byte());
        rx_bytes_q.push_back(cfrc_pkg::END_BYTE);
      end else begin
        // fill the store so the position wraps, then a frame with no start byte
        rx_bytes_q.push_back(cfrc_pkg::START_BYTE);
        repeat (cfrc_pkg::STORE_DEPTH - 1) rx_bytes_q.push_back(rand_data_byte());
        push_random_frame(rand_data_byte());
      end
    end
    bytes_total = rx_bytes_q.size();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (rx_bytes_q.size() != 0 || in_valid) @(posedge clk);
    while (frames_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes (%0d directed) through three idle phases", bytes_taken,
             directed_len);
    $display("frames reported %0d, checksum ok %0d, playback finished %0d, mismatches %0d",
             frames_seen, frames_good, frames_done, mismatches);
    if (frames_q.size() != 0) $display("%0d expected frames never arrived", frames_q.size());
    if (mismatches == 0 && frames_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
